// File: hdl/cat_pkg.sv
// ============================================================================
// cat_pkg
// Shared types, constants and the arctangent table for the angle tracker.
// ============================================================================
package cat_pkg;

    // default sizes, handed down through the top level parameters
    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int SAMPLE_WIDTH_DEFAULT = 24;

    // angle word and internal widths
    localparam int ANGLE_BITS  = 48;
    localparam int TURN_BITS   = 16;
    localparam int Z_BITS      = 17;
    localparam int D_BITS      = 19;
    localparam int GUARD_BITS  = 3;

    // angles in units of 2^-16 turn
    localparam int FULL_TURN    = 65536;
    localparam int HALF_TURN    = 32768;
    localparam int QUARTER_TURN = 16384;
    localparam int EIGHTH_TURN  = 8192;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [Z_BITS-1:0]     zangle_t;
    typedef logic signed [D_BITS-1:0]     delta_t;

    // atan(2^-step) in units of 2^-16 turn, rounded to nearest
    function automatic zangle_t atan_unit(input int step);
        zangle_t v;
        unique case (step)
            0:       v = zangle_t'(8192);
            1:       v = zangle_t'(4836);
            2:       v = zangle_t'(2555);
            3:       v = zangle_t'(1297);
            4:       v = zangle_t'(651);
            5:       v = zangle_t'(326);
            6:       v = zangle_t'(163);
            7:       v = zangle_t'(81);
            8:       v = zangle_t'(41);
            9:       v = zangle_t'(20);
            10:      v = zangle_t'(10);
            11:      v = zangle_t'(5);
            12:      v = zangle_t'(3);
            13:      v = zangle_t'(1);
            14:      v = zangle_t'(1);
            default: v = zangle_t'(0);
        endcase
        return v;
    endfunction

endpackage

// File: hdl/cat_cfg_if.sv
// ============================================================================
// cat_cfg_if
// Configuration write channel: one register word, valid/ready.
// ============================================================================
interface cat_cfg_if;
    logic valid;
    logic ready;
    logic half_turn_period;

    modport source (output valid, output half_turn_period, input ready);
    modport sink   (input valid, input half_turn_period, output ready);
endinterface

// File: hdl/cat_sample_if.sv
// ============================================================================
// cat_sample_if
// Input channel: vector components and previous continuous angle.
// ============================================================================
interface cat_sample_if #(
    parameter int SAMPLE_WIDTH = cat_pkg::SAMPLE_WIDTH_DEFAULT
);
    import cat_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] y_value;
    logic signed [SAMPLE_WIDTH-1:0] x_value;
    angle_t                         previous_angle;

    modport source (output valid, output y_value, output x_value,
                    output previous_angle, input ready);
    modport sink   (input valid, input y_value, input x_value,
                    input previous_angle, output ready);
endinterface

// File: hdl/cat_result_if.sv
// ============================================================================
// cat_result_if
// Output channel: continuous angle word.
// ============================================================================
interface cat_result_if;
    import cat_pkg::*;

    logic   valid;
    logic   ready;
    angle_t continuous_angle;

    modport source (output valid, output continuous_angle, input ready);
    modport sink   (input valid, input continuous_angle, output ready);
endinterface

// File: hdl/cat_prerot.sv
// ============================================================================
// cat_prerot
// Entry stage: sign extension, quarter-turn pre-rotation, zero detect.
// ============================================================================
module cat_prerot #(
    parameter int SAMPLE_WIDTH = cat_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int W            = cat_pkg::SAMPLE_WIDTH_DEFAULT + cat_pkg::GUARD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           feed_valid,
    output logic                           feed_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] feed_y,
    input  logic signed [SAMPLE_WIDTH-1:0] feed_x,
    input  cat_pkg::angle_t                feed_prev,
    output logic                           pass_valid,
    input  logic                           pass_ready,
    output logic signed [W-1:0]            pass_x,
    output logic signed [W-1:0]            pass_y,
    output cat_pkg::zangle_t               pass_z,
    output logic                           pass_zero,
    output cat_pkg::angle_t                pass_prev
);
    import cat_pkg::*;

    logic                valid_reg;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;
    zangle_t             z_reg, z_next;
    logic                zero_reg, zero_next;
    angle_t              prev_reg;
    logic signed [W-1:0] x_ext, y_ext;

    // stage takes a word when empty or when its word moves on
    assign feed_ready = !valid_reg || pass_ready;

    // sign extension into the guard bits
    assign x_ext = {{(W-SAMPLE_WIDTH){feed_x[SAMPLE_WIDTH-1]}}, feed_x};
    assign y_ext = {{(W-SAMPLE_WIDTH){feed_y[SAMPLE_WIDTH-1]}}, feed_y};

    // rotate left half plane by a quarter turn
    always_comb
    begin
        zero_next = (feed_x == '0) && (feed_y == '0);
        priority if (feed_x[SAMPLE_WIDTH-1] && !feed_y[SAMPLE_WIDTH-1])
        begin
            x_next = y_ext;
            y_next = -x_ext;
            z_next = zangle_t'(QUARTER_TURN);
        end
        else if (feed_x[SAMPLE_WIDTH-1])
        begin
            x_next = -y_ext;
            y_next = x_ext;
            z_next = -zangle_t'(QUARTER_TURN);
        end
        else
        begin
            x_next = x_ext;
            y_next = y_ext;
            z_next = '0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (feed_ready)
        begin
            valid_reg <= feed_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (feed_valid && feed_ready)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= zero_next;
            prev_reg <= feed_prev;
        end
    end

    assign pass_valid = valid_reg;
    assign pass_x     = x_reg;
    assign pass_y     = y_reg;
    assign pass_z     = z_reg;
    assign pass_zero  = zero_reg;
    assign pass_prev  = prev_reg;

endmodule

// File: hdl/cat_cell.sv
// ============================================================================
// cat_cell
// One vectoring CORDIC iteration with its own pipeline register.
// ============================================================================
module cat_cell #(
    parameter int W    = cat_pkg::SAMPLE_WIDTH_DEFAULT + cat_pkg::GUARD_BITS,
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                feed_valid,
    output logic                feed_ready,
    input  logic signed [W-1:0] feed_x,
    input  logic signed [W-1:0] feed_y,
    input  cat_pkg::zangle_t    feed_z,
    input  logic                feed_zero,
    input  cat_pkg::angle_t     feed_prev,
    output logic                pass_valid,
    input  logic                pass_ready,
    output logic signed [W-1:0] pass_x,
    output logic signed [W-1:0] pass_y,
    output cat_pkg::zangle_t    pass_z,
    output logic                pass_zero,
    output cat_pkg::angle_t     pass_prev
);
    import cat_pkg::*;

    localparam zangle_t STEP_ANGLE = atan_unit(STEP);

    logic                valid_reg;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;
    zangle_t             z_reg, z_next;
    logic                zero_reg;
    angle_t              prev_reg;
    logic signed [W-1:0] x_sh, y_sh;

    assign feed_ready = !valid_reg || pass_ready;

    // floor shifts of the old x and y
    assign x_sh = feed_x >>> STEP;
    assign y_sh = feed_y >>> STEP;

    // drive y toward zero
    always_comb
    begin
        if (!feed_y[W-1])
        begin
            x_next = feed_x + y_sh;
            y_next = feed_y - x_sh;
            z_next = feed_z + STEP_ANGLE;
        end
        else
        begin
            x_next = feed_x - y_sh;
            y_next = feed_y + x_sh;
            z_next = feed_z - STEP_ANGLE;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (feed_ready)
        begin
            valid_reg <= feed_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (feed_valid && feed_ready)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= feed_zero;
            prev_reg <= feed_prev;
        end
    end

    assign pass_valid = valid_reg;
    assign pass_x     = x_reg;
    assign pass_y     = y_reg;
    assign pass_z     = z_reg;
    assign pass_zero  = zero_reg;
    assign pass_prev  = prev_reg;

endmodule

// File: hdl/cat_unwrap.sv
// ============================================================================
// cat_unwrap
// Adds the vector angle's offset from the previous angle, folded by periods at +-1/8 turn.
// Two stages: offset from previous, then the wide add into the output word.
// ============================================================================
module cat_unwrap (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             half_turn_period,
    input  logic             feed_valid,
    output logic             feed_ready,
    input  cat_pkg::zangle_t feed_z,
    input  logic             feed_zero,
    input  cat_pkg::angle_t  feed_prev,
    output logic             pass_valid,
    input  logic             pass_ready,
    output cat_pkg::angle_t  continuous_angle
);
    import cat_pkg::*;

    localparam delta_t FULL_D     = delta_t'(FULL_TURN);
    localparam delta_t HALF_D     = delta_t'(HALF_TURN);
    localparam delta_t UPPER_D    = delta_t'(EIGHTH_TURN);
    localparam delta_t LOWER_D    = -delta_t'(EIGHTH_TURN);

    logic                 off_valid_reg;
    delta_t               off_reg;
    angle_t               prev_reg;
    logic                 out_valid_reg;
    angle_t               out_reg, out_next;
    logic                 off_ready;

    zangle_t              angle;
    logic [TURN_BITS-1:0] rem;
    delta_t               period;
    delta_t               d0, d1, d2, d3;

    // handshake chain across both stages
    assign off_ready  = !out_valid_reg || pass_ready;
    assign feed_ready = !off_valid_reg || off_ready;

    // offset of the candidate from previous, then fold into the window
    always_comb
    begin
        angle  = feed_zero ? '0 : feed_z;
        rem    = half_turn_period ? {1'b0, feed_prev[TURN_BITS-2:0]}
                                  : feed_prev[TURN_BITS-1:0];
        period = half_turn_period ? HALF_D : FULL_D;
        d0     = {{(D_BITS-Z_BITS){angle[Z_BITS-1]}}, angle}
               - {{(D_BITS-TURN_BITS){1'b0}}, rem};
        d1     = (d0 > UPPER_D) ? d0 - period : d0;
        d2     = (d1 < LOWER_D) ? d1 + period : d1;
        d3     = (d2 < LOWER_D) ? d2 + period : d2;
    end

    // final angle, wraps at the word width
    assign out_next = prev_reg + {{(ANGLE_BITS-D_BITS){off_reg[D_BITS-1]}}, off_reg};

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (feed_ready)
            begin
                off_valid_reg <= feed_valid;
            end
            if (off_ready)
            begin
                out_valid_reg <= off_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (feed_valid && feed_ready)
        begin
            off_reg  <= d3;
            prev_reg <= feed_prev;
        end
        if (off_valid_reg && off_ready)
        begin
            out_reg <= out_next;
        end
    end

    assign pass_valid       = out_valid_reg;
    assign continuous_angle = out_reg;

endmodule

// File: hdl/continuous_atan2_angle_tracker.sv
// ============================================================================
// continuous_atan2_angle_tracker
// Vector angle by a pipelined vectoring CORDIC, unwrapped to the nearest
// continuous angle around the previous one.
// ============================================================================
//  channel  | role   | word
//  ---------+--------+-------------------------------------------------
//  cfg      | sink   | half_turn_period (0 full-turn, 1 half-turn period)
//  sample   | sink   | y_value, x_value, previous_angle
//  result   | source | continuous_angle
//
//  one word per cycle while the result is taken; one pre-rotation
//  stage, one cell per CORDIC iteration, two unwrap stages.
//  every stage has its own valid bit and takes a new word while its own word
//  moves on, so bubbles close up behind a stalled result.
//  reset clears all valid bits and sets the period to a full turn.
//  cfg is always ready and takes effect for words still to be unwrapped.
// ============================================================================
module continuous_atan2_angle_tracker #(
    parameter int CORDIC_STEPS = cat_pkg::CORDIC_STEPS_DEFAULT,
    parameter int SAMPLE_WIDTH = cat_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    cat_cfg_if.sink      cfg,
    cat_sample_if.sink   sample,
    cat_result_if.source result
);
    import cat_pkg::*;

    localparam int W = SAMPLE_WIDTH + GUARD_BITS;

    logic                half_turn_period_reg;

    logic                valid_s [CORDIC_STEPS+1];
    logic                ready_s [CORDIC_STEPS+1];
    logic signed [W-1:0] x_s     [CORDIC_STEPS+1];
    logic signed [W-1:0] y_s     [CORDIC_STEPS+1];
    zangle_t             z_s     [CORDIC_STEPS+1];
    logic                zero_s  [CORDIC_STEPS+1];
    angle_t              prev_s  [CORDIC_STEPS+1];

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_turn_period_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            half_turn_period_reg <= cfg.half_turn_period;
        end
    end

    // quarter-turn pre-rotation
    cat_prerot #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .W            (W)
    ) u_prerot (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed_valid (sample.valid),
        .feed_ready (sample.ready),
        .feed_y     (sample.y_value),
        .feed_x     (sample.x_value),
        .feed_prev  (sample.previous_angle),
        .pass_valid (valid_s[0]),
        .pass_ready (ready_s[0]),
        .pass_x     (x_s[0]),
        .pass_y     (y_s[0]),
        .pass_z     (z_s[0]),
        .pass_zero  (zero_s[0]),
        .pass_prev  (prev_s[0])
    );

    // row of CORDIC cells, one per iteration
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        cat_cell #(
            .W    (W),
            .STEP (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .feed_valid (valid_s[i]),
            .feed_ready (ready_s[i]),
            .feed_x     (x_s[i]),
            .feed_y     (y_s[i]),
            .feed_z     (z_s[i]),
            .feed_zero  (zero_s[i]),
            .feed_prev  (prev_s[i]),
            .pass_valid (valid_s[i+1]),
            .pass_ready (ready_s[i+1]),
            .pass_x     (x_s[i+1]),
            .pass_y     (y_s[i+1]),
            .pass_z     (z_s[i+1]),
            .pass_zero  (zero_s[i+1]),
            .pass_prev  (prev_s[i+1])
        );
    end

    // unwrap and output register
    cat_unwrap u_unwrap (
        .clk              (clk),
        .rst_n            (rst_n),
        .half_turn_period (half_turn_period_reg),
        .feed_valid       (valid_s[CORDIC_STEPS]),
        .feed_ready       (ready_s[CORDIC_STEPS]),
        .feed_z           (z_s[CORDIC_STEPS]),
        .feed_zero        (zero_s[CORDIC_STEPS]),
        .feed_prev        (prev_s[CORDIC_STEPS]),
        .pass_valid       (result.valid),
        .pass_ready       (result.ready),
        .continuous_angle (result.continuous_angle)
    );

endmodule
